// ----- rtl/mbr_pkg.sv -----
// Shared constants, types and codes for the MSB-first bit reader.
package mbr_pkg;

  localparam int unsigned MAX_BYTES = 4096;
  localparam int unsigned ADDR_W    = $clog2(MAX_BYTES);
  localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int unsigned CACHE_W   = 40;
  localparam int unsigned CBITS_W   = 6;
  localparam int unsigned MAX_READ  = 32;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_READ   = 3'd2,
    OP_PEEK   = 3'd3,
    OP_SKIP   = 3'd4,
    OP_ALIGN  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic accept;
    logic fill;
    logic exec;
  } ctl_t;

endpackage

// ----- rtl/mbr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module mbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/mbr_extract.sv -----
// Shared shift unit: takes count bits from the top of the valid part of the cache.
module mbr_extract (
  input  logic [mbr_pkg::CACHE_W-1:0] cache_i,
  input  logic [mbr_pkg::CBITS_W-1:0] cached_i,
  input  logic [mbr_pkg::CBITS_W-1:0] count_i,
  output logic [mbr_pkg::MAX_READ-1:0] value_o,
  output logic [mbr_pkg::CACHE_W-1:0] cache_o,
  output logic [mbr_pkg::CBITS_W-1:0] cached_o
);
  import mbr_pkg::*;

  logic                  short_w;
  logic [CBITS_W-1:0]    sh_w;
  logic [MAX_READ-1:0]   mask_n_w;
  logic [MAX_READ-1:0]   mask_c_w;
  logic [CACHE_W-1:0]    shifted_w;

  always_comb begin
    short_w   = cached_i < count_i;
    sh_w      = cached_i - count_i;
    mask_n_w  = ~({MAX_READ{1'b1}} << count_i);
    mask_c_w  = ~({MAX_READ{1'b1}} << cached_i);
    shifted_w = cache_i >> sh_w;
    if (short_w) begin
      // Too few bits left: hand back what there is and empty the cache.
      value_o  = cache_i[MAX_READ-1:0] & mask_c_w;
      cache_o  = '0;
      cached_o = '0;
    end else begin
      value_o  = shifted_w[MAX_READ-1:0] & mask_n_w;
      cache_o  = cache_i & ~({CACHE_W{1'b1}} << sh_w);
      cached_o = sh_w;
    end
  end

endmodule

// ----- rtl/mbr_seq.sv -----
// Sequencer: idle, byte refill loop and the single execute step.
module mbr_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          more_i,
  output logic          busy_o,
  output mbr_pkg::ctl_t ctl_o
);
  import mbr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.accept = 1'b1;
          state_d      = ST_FILL;
        end
      end
      ST_FILL: begin
        ctl_o.fill = 1'b1;
        if (!more_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ----- rtl/msb_first_bit_reader_unit.sv -----
// The strobe follows the refill loop and the execute step; the loop pulls from the byte memory
// into the cache only the bytes the command still needs (0 to 4).
// The refill loop reads one byte per cycle from the memory's single read port.
// A new command is not taken while busy; start is taken again in the strobe cycle.
// Reset clears the counters and the cache at once, so the store reads as empty;
// the byte memory itself is not cleared and needs no clearing pass.
module msb_first_bit_reader_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   op_i,
  input  logic [5:0]                   bit_count_i,
  input  logic [7:0]                   data_byte_i,
  output logic                         valid_o,
  output logic [31:0]                  value_o,
  output logic [15:0]                  bit_position_o,
  output logic [15:0]                  bits_remaining_o
);
  import mbr_pkg::*;

  ctl_t               ctl_w;
  logic               more_w;

  op_e                op_q;
  logic [CBITS_W-1:0] n_q, need_q;
  logic [7:0]         byte_q;
  logic [CNT_W-1:0]   bc_q, bc_d;
  logic [CNT_W-1:0]   ri_q, ri_d;
  logic [CACHE_W-1:0] cache_q, cache_d;
  logic [CBITS_W-1:0] cached_q, cached_d;
  logic               pend_q, pend_d;
  logic               valid_q;
  logic [31:0]        value_q, value_d;
  logic [15:0]        pos_q, pos_d;
  logic [15:0]        rem_q, rem_d;

  logic [CBITS_W-1:0] n_sat_w;
  logic               is_bits_op_w;
  logic [CACHE_W-1:0] cache_a_w;
  logic [CBITS_W-1:0] cached_a_w;
  logic [CNT_W-1:0]   ri_a_w;
  logic [7:0]         rdata_w;
  logic               ram_we_w;

  logic [CBITS_W-1:0]  ex_n_w;
  logic [MAX_READ-1:0] ex_value_w;
  logic [CACHE_W-1:0]  ex_cache_w;
  logic [CBITS_W-1:0]  ex_cached_w;

  mbr_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .more_i (more_w),
    .busy_o (busy),
    .ctl_o  (ctl_w)
  );

  mbr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we_w),
    .waddr_i(bc_q[ADDR_W-1:0]),
    .wdata_i(byte_q),
    .re_i   (ctl_w.fill & more_w),
    .raddr_i(ri_a_w[ADDR_W-1:0]),
    .rdata_o(rdata_w)
  );

  mbr_extract u_ext (
    .cache_i (cache_q),
    .cached_i(cached_q),
    .count_i (ex_n_w),
    .value_o (ex_value_w),
    .cache_o (ex_cache_w),
    .cached_o(ex_cached_w)
  );

  always_comb begin
    n_sat_w = (bit_count_i > CBITS_W'(MAX_READ)) ? CBITS_W'(MAX_READ) : bit_count_i;
    is_bits_op_w = (op_i == OP_READ) || (op_i == OP_PEEK) || (op_i == OP_SKIP);
  end

  // A byte read in the previous fill cycle is absorbed here, and the next read is
  // decided on the counts after absorbing it, so the loop moves one byte per cycle.
  always_comb begin
    if (pend_q) begin
      cache_a_w  = {cache_q[CACHE_W-9:0], rdata_w};
      cached_a_w = cached_q + CBITS_W'(8);
      ri_a_w     = ri_q + CNT_W'(1);
    end else begin
      cache_a_w  = cache_q;
      cached_a_w = cached_q;
      ri_a_w     = ri_q;
    end
    more_w = (cached_a_w < need_q) && (ri_a_w < bc_q);
  end

  assign ex_n_w   = (op_q == OP_ALIGN) ? {{(CBITS_W-3){1'b0}}, cached_q[2:0]} : n_q;
  assign ram_we_w = ctl_w.exec && (op_q == OP_APPEND) && (bc_q < CNT_W'(MAX_BYTES));

  always_comb begin
    bc_d     = bc_q;
    ri_d     = ri_q;
    cache_d  = cache_q;
    cached_d = cached_q;
    pend_d   = pend_q;
    value_d  = '0;
    if (ctl_w.accept) begin
      pend_d = 1'b0;
    end
    if (ctl_w.fill) begin
      cache_d  = cache_a_w;
      cached_d = cached_a_w;
      ri_d     = ri_a_w;
      pend_d   = more_w;
    end
    if (ctl_w.exec) begin
      case (op_q)
        OP_CLEAR: begin
          bc_d     = '0;
          ri_d     = '0;
          cache_d  = '0;
          cached_d = '0;
        end
        OP_APPEND: begin
          if (ram_we_w) begin
            bc_d = bc_q + CNT_W'(1);
          end
        end
        OP_READ: begin
          value_d  = ex_value_w;
          cache_d  = ex_cache_w;
          cached_d = ex_cached_w;
        end
        OP_PEEK: begin
          value_d = ex_value_w;
        end
        OP_SKIP, OP_ALIGN: begin
          cache_d  = ex_cache_w;
          cached_d = ex_cached_w;
        end
        default: begin
        end
      endcase
    end
    pos_d = 16'({ri_d, 3'b000} - (CNT_W+3)'(cached_d));
    rem_d = 16'({bc_d - ri_d, 3'b000} + (CNT_W+3)'(cached_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q     <= '0;
      ri_q     <= '0;
      cache_q  <= '0;
      cached_q <= '0;
      pend_q   <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      bc_q     <= bc_d;
      ri_q     <= ri_d;
      cache_q  <= cache_d;
      cached_q <= cached_d;
      pend_q   <= pend_d;
      valid_q  <= ctl_w.exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_w.accept) begin
      op_q   <= op_e'(op_i);
      n_q    <= n_sat_w;
      need_q <= is_bits_op_w ? n_sat_w : '0;
      byte_q <= data_byte_i;
    end
    if (ctl_w.exec) begin
      value_q <= value_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
    end
  end

  assign valid_o          = valid_q;
  assign value_o          = value_q;
  assign bit_position_o   = pos_q;
  assign bits_remaining_o = rem_q;

endmodule

// ----- rtl/mbr_checker.sv -----
// Port-level checks on the command handshake and result strobe of the bit reader.
module mbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        valid_o,
  input logic [31:0] value_o
);

  // A result word only appears once the unit has gone idle again.
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while busy");

  // The strobe marks the cycle in which the unit drops busy.
  a_strobe_fell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $fell(busy))
    else $error("result strobe without end of command");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // No result can follow an accepted command in the very next cycle.
  a_accept_no_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !valid_o)
    else $error("result strobe directly after accepting a command");

  // Every strobed word carries a fully defined value.
  a_value_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !$isunknown(value_o))
    else $error("result strobe with undefined value");

endmodule

bind msb_first_bit_reader_unit mbr_checker u_mbr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .valid_o(valid_o),
  .value_o(value_o)
);
